// ----- rtl/fragment_packer_with_dedup_top_macros.svh -----
// ----------------------------------------------------------------------------
// Fragment packer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FRAGMENT_PACKER_WITH_DEDUP_TOP_MACROS_SVH
`define FRAGMENT_PACKER_WITH_DEDUP_TOP_MACROS_SVH

// Same-cycle implication.
`define FPD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fragment packer check failed");

// Next-cycle implication.
`define FPD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fragment packer check failed");

`endif

// ----- rtl/fpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Fragment packer package
// Sizes, codes and record types shared by the fragment packer files.
// ----------------------------------------------------------------------------
package fpd_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int CSUM_W   = 32;
    localparam int LEN_W    = 21;
    localparam int BLOCK_W  = 32;
    localparam int OFFSET_W = 20;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 112;
    localparam int M_TUSER_W = 4;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [LEN_W-1:0] MAX_BLOCK_RESET = LEN_W'(131072);

    // register index (paddr[2])
    localparam logic REG_MAX_BLOCK_BYTES = 1'b0;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_TOO_LARGE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_HIT    = 4'b0100,
        ST_MISS   = 4'b1000
    } state_t;

    typedef struct packed {
        logic [CSUM_W-1:0]   csum;
        logic [LEN_W-1:0]    len;
        logic [BLOCK_W-1:0]  block;
        logic [OFFSET_W-1:0] offset;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic                flushed_no_compress;
        logic [LEN_W-1:0]    flushed_fill;
        logic [BLOCK_W-1:0]  flushed_block;
        logic [OFFSET_W-1:0] placed_offset;
        logic [BLOCK_W-1:0]  placed_block;
    } result_data_t;

    typedef struct packed {
        status_t status;
        logic    flush_valid;
        logic    is_duplicate;
    } result_user_t;

endpackage

// ----- rtl/fpd_ram.sv -----
// ----------------------------------------------------------------------------
// Fragment packer generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/fragment_packer_with_dedup_top.sv -----
// ----------------------------------------------------------------------------
// Fragment packer with deduplication
// Looks each fragment up in a dedup table; a miss that fits and finds room is
// placed next-fit into the open block, closing it when it would overflow.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                 Words carried
// s_axis    in   s_axis_tvalid/tready      one fragment descriptor
// m_axis    out  m_axis_tvalid/tready      one placement result
// apb       in   psel/penable/pwrite       max_block_bytes register write/read
//
// Sequence: an accepted fragment scans the table, then writes a registered
// result (with an empty table the scan is skipped; a hit ends it early); the
// scan reads one entry a cycle through the single read port of the table
// RAM, and the next descriptor is taken only after the result is registered.
// Reset: rst_n clears the sequencer, the entry count and the open-block
// state; table contents are not cleared and are read only below the count.
// Stalls: the result waits in an output register; the block accepts the next
// descriptor while it waits, and holds the final step until the slot frees.
//
module fragment_packer_with_dedup_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // [31:0] frag_checksum, [52:32] frag_bytes, rest zero
    input  logic [fpd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [0] frag_no_compress
    input  logic                            s_axis_tuser,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] placed_block, [51:32] placed_offset, [83:52] flushed_block,
    // [104:84] flushed_fill, [105] flushed_no_compress, rest zero
    output logic [fpd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // [0] is_duplicate, [1] flush_valid, [3:2] status
    output logic [fpd_pkg::M_TUSER_W-1:0]   m_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fpd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [fpd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [fpd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

`include "fragment_packer_with_dedup_top_macros.svh"

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [fpd_pkg::LEN_W-1:0] max_bytes_reg;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == fpd_pkg::REG_MAX_BLOCK_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= fpd_pkg::MAX_BLOCK_RESET;
        end
        else if (cfg_wr)
        begin
            max_bytes_reg <= pwdata[fpd_pkg::LEN_W-1:0];
        end
    end

    // Read back: only the one register is defined, everything else reads zero.
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == fpd_pkg::REG_MAX_BLOCK_BYTES)
        begin
            prdata = fpd_pkg::APB_DATA_W'(max_bytes_reg);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and packing state
    // ------------------------------------------------------------------
    fpd_pkg::state_t                 state_reg, state_next;
    logic [fpd_pkg::CNT_W-1:0]       entry_count_reg, entry_count_next;
    logic                            block_open_reg, block_open_next;
    logic [fpd_pkg::BLOCK_W-1:0]     open_index_reg, open_index_next;
    logic [fpd_pkg::LEN_W-1:0]       open_fill_reg, open_fill_next;
    logic                            open_raw_reg, open_raw_next;
    logic [fpd_pkg::BLOCK_W-1:0]     next_index_reg, next_index_next;

    // Scan pointer and read pipeline tracking
    logic [fpd_pkg::CNT_W-1:0]       issue_cnt_reg, issue_cnt_next;
    logic                            rd_pend_reg, rd_pend_next;
    logic                            cmp_last_reg, cmp_last_next;

    // Latched descriptor (payload, no reset)
    logic [fpd_pkg::CSUM_W-1:0]      in_csum_reg, in_csum_next;
    logic [fpd_pkg::LEN_W-1:0]       in_len_reg, in_len_next;
    logic                            in_raw_reg, in_raw_next;
    logic [fpd_pkg::BLOCK_W-1:0]     hit_block_reg, hit_block_next;
    logic [fpd_pkg::OFFSET_W-1:0]    hit_offset_reg, hit_offset_next;

    // Output register
    logic                            out_valid_reg, out_valid_next;
    fpd_pkg::result_data_t           out_data_reg, out_data_next;
    fpd_pkg::result_user_t           out_user_reg, out_user_next;

    // Table RAM ports
    logic                            ram_we;
    logic [fpd_pkg::IDX_W-1:0]       ram_waddr;
    fpd_pkg::entry_t                 ram_wdata;
    logic                            ram_re;
    logic [fpd_pkg::IDX_W-1:0]       ram_raddr;
    fpd_pkg::entry_t                 ram_rdata;

    // Miss-path arithmetic
    logic                            in_accept;
    logic                            out_free;
    logic                            entry_match;
    logic                            too_large;
    logic                            table_full;
    logic                            need_flush;
    logic                            open_new;
    logic [fpd_pkg::LEN_W:0]         fill_sum;
    logic [fpd_pkg::BLOCK_W-1:0]     place_index;
    logic [fpd_pkg::LEN_W-1:0]       place_fill;

    assign s_axis_tready = (state_reg == fpd_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign entry_match = (ram_rdata.csum == in_csum_reg) && (ram_rdata.len == in_len_reg);

    assign too_large  = (in_len_reg > max_bytes_reg);
    assign table_full = (entry_count_reg == fpd_pkg::CNT_W'(fpd_pkg::TABLE_ENTRIES));
    assign fill_sum   = {1'b0, open_fill_reg} + {1'b0, in_len_reg};
    assign need_flush = block_open_reg && (fill_sum > {1'b0, max_bytes_reg});
    assign open_new   = !block_open_reg || need_flush;
    assign place_index = open_new ? next_index_reg : open_index_reg;
    assign place_fill  = open_new ? '0 : open_fill_reg;

    assign ram_waddr = entry_count_reg[fpd_pkg::IDX_W-1:0];
    assign ram_raddr = issue_cnt_reg[fpd_pkg::IDX_W-1:0];

    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        block_open_next  = block_open_reg;
        open_index_next  = open_index_reg;
        open_fill_next   = open_fill_reg;
        open_raw_next    = open_raw_reg;
        next_index_next  = next_index_reg;
        issue_cnt_next   = issue_cnt_reg;
        rd_pend_next     = 1'b0;
        cmp_last_next    = cmp_last_reg;
        in_csum_next     = in_csum_reg;
        in_len_next      = in_len_reg;
        in_raw_next      = in_raw_reg;
        hit_block_next   = hit_block_reg;
        hit_offset_next  = hit_offset_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_data_next    = out_data_reg;
        out_user_next    = out_user_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_wdata        = '0;

        case (state_reg)
            fpd_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    in_csum_next   = s_axis_tdata[fpd_pkg::CSUM_W-1:0];
                    in_len_next    = s_axis_tdata[fpd_pkg::CSUM_W +: fpd_pkg::LEN_W];
                    in_raw_next    = s_axis_tuser;
                    issue_cnt_next = '0;
                    // empty table: nothing to scan
                    state_next = (entry_count_reg == '0) ? fpd_pkg::ST_MISS
                                                         : fpd_pkg::ST_SEARCH;
                end
            end

            fpd_pkg::ST_SEARCH:
            begin
                if (rd_pend_reg && entry_match)
                begin
                    hit_block_next  = ram_rdata.block;
                    hit_offset_next = ram_rdata.offset;
                    state_next      = fpd_pkg::ST_HIT;
                end
                else if (rd_pend_reg && cmp_last_reg)
                begin
                    state_next = fpd_pkg::ST_MISS;
                end
                else if (issue_cnt_reg < entry_count_reg)
                begin
                    // issue the next table read; compare it once the registered read data returns
                    ram_re         = 1'b1;
                    rd_pend_next   = 1'b1;
                    cmp_last_next  = ((issue_cnt_reg + 1'b1) == entry_count_reg);
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
            end

            fpd_pkg::ST_HIT:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next               = '0;
                    out_data_next.placed_block  = hit_block_reg;
                    out_data_next.placed_offset = hit_offset_reg;
                    out_user_next               = '0;
                    out_user_next.is_duplicate  = 1'b1;
                    out_user_next.status        = fpd_pkg::STATUS_OK;
                    state_next                  = fpd_pkg::ST_IDLE;
                end
            end

            fpd_pkg::ST_MISS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_user_next  = '0;
                    state_next     = fpd_pkg::ST_IDLE;
                    if (too_large)
                    begin
                        out_user_next.status = fpd_pkg::STATUS_TOO_LARGE;
                    end
                    else if (table_full)
                    begin
                        out_user_next.status = fpd_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        out_user_next.status = fpd_pkg::STATUS_OK;
                        if (need_flush)
                        begin
                            out_user_next.flush_valid         = 1'b1;
                            out_data_next.flushed_block       = open_index_reg;
                            out_data_next.flushed_fill        = open_fill_reg;
                            out_data_next.flushed_no_compress = open_raw_reg;
                        end
                        out_data_next.placed_block  = place_index;
                        out_data_next.placed_offset = place_fill[fpd_pkg::OFFSET_W-1:0];

                        // record the new entry
                        ram_we           = 1'b1;
                        ram_wdata.csum   = in_csum_reg;
                        ram_wdata.len    = in_len_reg;
                        ram_wdata.block  = place_index;
                        ram_wdata.offset = place_fill[fpd_pkg::OFFSET_W-1:0];
                        entry_count_next = entry_count_reg + 1'b1;

                        // advance the open block
                        block_open_next = 1'b1;
                        open_index_next = place_index;
                        if (open_new)
                        begin
                            next_index_next = next_index_reg + 1'b1;
                        end
                        open_fill_next = place_fill + in_len_reg;
                        open_raw_next  = (open_new ? 1'b0 : open_raw_reg) || in_raw_reg;
                    end
                end
            end

            default:
            begin
                state_next = fpd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= fpd_pkg::ST_IDLE;
            entry_count_reg <= '0;
            block_open_reg  <= 1'b0;
            open_index_reg  <= '0;
            open_fill_reg   <= '0;
            open_raw_reg    <= 1'b0;
            next_index_reg  <= '0;
            issue_cnt_reg   <= '0;
            rd_pend_reg     <= 1'b0;
            cmp_last_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            block_open_reg  <= block_open_next;
            open_index_reg  <= open_index_next;
            open_fill_reg   <= open_fill_next;
            open_raw_reg    <= open_raw_next;
            next_index_reg  <= next_index_next;
            issue_cnt_reg   <= issue_cnt_next;
            rd_pend_reg     <= rd_pend_next;
            cmp_last_reg    <= cmp_last_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_csum_reg    <= in_csum_next;
        in_len_reg     <= in_len_next;
        in_raw_reg     <= in_raw_next;
        hit_block_reg  <= hit_block_next;
        hit_offset_reg <= hit_offset_next;
        out_data_reg   <= out_data_next;
        out_user_reg   <= out_user_next;
    end

    // ------------------------------------------------------------------
    // Dedup table
    // ------------------------------------------------------------------
    fpd_ram #(
        .WIDTH (fpd_pkg::ENTRY_W),
        .DEPTH (fpd_pkg::TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = fpd_pkg::M_TDATA_W'(out_data_reg);
    assign m_axis_tuser  = out_user_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `FPD_ASSERT_IMP(a_count_bound, 1'b1,
        entry_count_reg <= fpd_pkg::CNT_W'(fpd_pkg::TABLE_ENTRIES))
    `FPD_ASSERT_NXT(a_table_write_counts, ram_we,
        entry_count_reg == $past(entry_count_reg) + 1'b1)
    `FPD_ASSERT_IMP(a_error_zero_payload,
        out_valid_reg && (out_user_reg.status != fpd_pkg::STATUS_OK),
        (out_data_reg == '0) && !out_user_reg.flush_valid && !out_user_reg.is_duplicate)
    `FPD_ASSERT_IMP(a_dup_no_flush, out_valid_reg && out_user_reg.is_duplicate,
        !out_user_reg.flush_valid)
    `FPD_ASSERT_IMP(a_scan_in_range, ram_re,
        issue_cnt_reg < entry_count_reg)

endmodule

// ----- bench/tb_fragment_packer_with_dedup_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fragment packer with deduplication testbench
// Streams fragment descriptors into the packer and checks every placement word
// against a local next-fit and dedup predictor. A directed table opens the run
// (reset state, field extremes, flushes, oversize and zero-length fragments,
// capacity changes); random phases at several block capacities follow.
// ----------------------------------------------------------------------------
module tb_fragment_packer_with_dedup_top;

    localparam int CLK_PERIOD = 4;
    localparam int MAX_FRAG   = 1048576;          // largest legal fragment and capacity
    localparam int MIN_CAP    = 4096;
    localparam int PHASE_LEN  = 112;              // random words per capacity setting
    localparam int TAIL_WAIT  = fpd_pkg::TABLE_ENTRIES + 8; // longest scan plus margin
    localparam logic [fpd_pkg::APB_ADDR_W-1:0] MAX_BLOCK_ADDR =
        fpd_pkg::APB_ADDR_W'({fpd_pkg::REG_MAX_BLOCK_BYTES, 2'b00});

    // One expected placement word: sideband flags and the packed data fields.
    typedef struct packed {
        fpd_pkg::result_user_t u;
        fpd_pkg::result_data_t d;
    } placement_t;

    typedef enum logic { ROW_REG, ROW_FRAG } row_kind_t;

    // Directed row: a register write (bytes holds the capacity) or a fragment.
    typedef struct {
        row_kind_t                  kind;
        logic [fpd_pkg::CSUM_W-1:0] csum;
        logic [fpd_pkg::LEN_W-1:0]  bytes;
        logic                       raw;
        bit                         typed;
        placement_t                 want;
    } plan_row_t;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic [fpd_pkg::S_TDATA_W-1:0]     s_axis_tdata;
    logic                              s_axis_tuser;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [fpd_pkg::M_TDATA_W-1:0]     m_axis_tdata;
    logic [fpd_pkg::M_TUSER_W-1:0]     m_axis_tuser;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [fpd_pkg::APB_ADDR_W-1:0]    paddr;
    logic [fpd_pkg::APB_DATA_W-1:0]    pwdata;
    logic [fpd_pkg::APB_DATA_W-1:0]    prdata;
    logic                              pready;

    // Predictor state: dedup table, open block and capacity register.
    logic [fpd_pkg::CSUM_W-1:0]   seen_csum   [fpd_pkg::TABLE_ENTRIES];
    logic [fpd_pkg::LEN_W-1:0]    seen_len    [fpd_pkg::TABLE_ENTRIES];
    logic [fpd_pkg::BLOCK_W-1:0]  seen_block  [fpd_pkg::TABLE_ENTRIES];
    logic [fpd_pkg::OFFSET_W-1:0] seen_offset [fpd_pkg::TABLE_ENTRIES];
    int                           seen_count;
    logic                         open_valid;
    logic [fpd_pkg::BLOCK_W-1:0]  open_index;
    logic [fpd_pkg::LEN_W-1:0]    open_fill;
    logic                         open_raw;
    logic [fpd_pkg::BLOCK_W-1:0]  fresh_index;
    logic [fpd_pkg::LEN_W-1:0]    block_cap;

    placement_t                   placement_q [$];   // expected words, oldest first
    plan_row_t                    plan_rows [$];
    logic [fpd_pkg::CSUM_W-1:0]   sent_csum [$];     // every descriptor sent, for repeats
    logic [fpd_pkg::LEN_W-1:0]    sent_len  [$];

    bit no_idle = 1'b0;   // set to run both sides back to back
    int mismatches    = 0;
    int frags_sent    = 0;
    int cap_writes    = 0;
    int dup_seen      = 0;
    int flush_seen    = 0;
    int oversize_seen = 0;
    int full_seen     = 0;

    fragment_packer_with_dedup_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Look the fragment up, then place it next-fit; update state and return
    // the placement word the block should produce.
    function automatic placement_t place_fragment(input logic [fpd_pkg::CSUM_W-1:0] csum,
                                                  input logic [fpd_pkg::LEN_W-1:0] len,
                                                  input logic raw);
        placement_t p;
        p = '0;
        // Dedup search comes before any size or table check.
        for (int i = 0; i < seen_count; i++)
        begin
            if (seen_csum[i] == csum && seen_len[i] == len)
            begin
                p.u.is_duplicate  = 1'b1;
                p.d.placed_block  = seen_block[i];
                p.d.placed_offset = seen_offset[i];
                return p;
            end
        end
        if (len > block_cap)
        begin
            p.u.status = fpd_pkg::STATUS_TOO_LARGE;
            return p;
        end
        if (seen_count >= fpd_pkg::TABLE_ENTRIES)
        begin
            p.u.status = fpd_pkg::STATUS_FULL;
            return p;
        end
        // Close the open block when the fragment would run past the capacity.
        if (open_valid && int'(open_fill) + int'(len) > int'(block_cap))
        begin
            p.u.flush_valid           = 1'b1;
            p.d.flushed_block         = open_index;
            p.d.flushed_fill          = open_fill;
            p.d.flushed_no_compress   = open_raw;
            open_valid                = 1'b0;
        end
        if (!open_valid)
        begin
            open_valid  = 1'b1;
            open_index  = fresh_index;
            fresh_index = fresh_index + 1'b1;
            open_fill   = '0;
            open_raw    = 1'b0;
        end
        seen_csum[seen_count]   = csum;
        seen_len[seen_count]    = len;
        seen_block[seen_count]  = open_index;
        seen_offset[seen_count] = open_fill[fpd_pkg::OFFSET_W-1:0];   // offset keeps 20 bits
        seen_count++;
        p.d.placed_block  = open_index;
        p.d.placed_offset = open_fill[fpd_pkg::OFFSET_W-1:0];
        open_raw  = open_raw | raw;
        open_fill = open_fill + len;
        return p;
    endfunction

    function automatic placement_t outcome(input bit dup, input int unsigned blk,
                                           input int unsigned off, input bit flush,
                                           input int unsigned fblk, input int unsigned fill,
                                           input bit fraw, input fpd_pkg::status_t st);
        placement_t p;
        p = '0;
        p.u.is_duplicate        = dup;
        p.u.flush_valid         = flush;
        p.u.status              = st;
        p.d.placed_block        = blk;
        p.d.placed_offset       = fpd_pkg::OFFSET_W'(off);
        p.d.flushed_block       = fblk;
        p.d.flushed_fill        = fpd_pkg::LEN_W'(fill);
        p.d.flushed_no_compress = fraw;
        return p;
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic row_frag(input logic [fpd_pkg::CSUM_W-1:0] csum,
                            input logic [fpd_pkg::LEN_W-1:0] len, input logic raw);
        plan_rows.push_back('{ROW_FRAG, csum, len, raw, 1'b0, '0});
    endtask

    task automatic row_check(input logic [fpd_pkg::CSUM_W-1:0] csum,
                             input logic [fpd_pkg::LEN_W-1:0] len,
                             input logic raw, input placement_t want);
        plan_rows.push_back('{ROW_FRAG, csum, len, raw, 1'b1, want});
    endtask

    task automatic row_reg(input logic [fpd_pkg::LEN_W-1:0] value);
        plan_rows.push_back('{ROW_REG, '0, value, 1'b0, 1'b0, '0});
    endtask

    // Offer one descriptor after a random gap; predict at the accepting edge.
    // A typed expectation, when given, replaces the predicted one.
    task automatic send_fragment(input logic [fpd_pkg::CSUM_W-1:0] csum,
                                 input logic [fpd_pkg::LEN_W-1:0] len,
                                 input logic raw, input bit typed, input placement_t want);
        int gap;
        placement_t p;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= fpd_pkg::S_TDATA_W'({len, csum});
        s_axis_tuser  <= raw;
        do @(posedge clk); while (!s_axis_tready);
        p = place_fragment(csum, len, raw);
        placement_q.push_back(typed ? want : p);
        sent_csum.push_back(csum);
        sent_len.push_back(len);
        frags_sent++;
    endtask

    // Mix of repeats, oversize fragments, checksum reuse with a new length,
    // whole-block fragments, fresh ones up to the capacity and small fresh ones.
    task automatic send_random(input int dup_pct);
        logic [fpd_pkg::CSUM_W-1:0] csum;
        logic [fpd_pkg::LEN_W-1:0]  len;
        int unsigned                pick;
        int unsigned                k;
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, sent_csum.size() - 1);
        csum = $urandom;
        len  = fpd_pkg::LEN_W'($urandom_range(1, block_cap / 16));
        if (pick < dup_pct)
        begin
            csum = sent_csum[k];
            len  = sent_len[k];
        end
        else if (pick < dup_pct + 5 && block_cap < MAX_FRAG)
            len = fpd_pkg::LEN_W'($urandom_range(block_cap + 1, MAX_FRAG));
        else if (pick < dup_pct + 12)
            csum = sent_csum[k];
        else if (pick < dup_pct + 17)
            len = block_cap;
        else if (pick < dup_pct + 37)
            len = fpd_pkg::LEN_W'($urandom_range(1, block_cap));
        send_fragment(csum, len, logic'($urandom_range(0, 3) == 0), 1'b0, '0);
    endtask

    // Drop valid and hold until every expected word has come back.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (placement_q.size() != 0) @(posedge clk);
    endtask

    // Setup then access cycle; the register takes the value on the access edge.
    task automatic write_max_block(input logic [fpd_pkg::LEN_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_BLOCK_ADDR;
        pwdata  <= fpd_pkg::APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        block_cap = value;
        cap_writes++;
    endtask

    // Result side: stall at random, then take one word and check it against
    // the oldest expectation.
    initial
    begin
        placement_t            want;
        fpd_pkg::result_data_t got_d;
        fpd_pkg::result_user_t got_u;
        int                    stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (m_axis_tvalid !== 1'b1);
            got_d = m_axis_tdata[$bits(fpd_pkg::result_data_t)-1:0];
            got_u = m_axis_tuser;
            if (placement_q.size() == 0)
            begin
                $error("placement word with no expectation waiting");
                mismatches++;
            end
            else
            begin
                want = placement_q.pop_front();
                compare_field("is_duplicate", 64'(want.u.is_duplicate),
                              64'(got_u.is_duplicate));
                compare_field("placed_block", 64'(want.d.placed_block),
                              64'(got_d.placed_block));
                compare_field("placed_offset", 64'(want.d.placed_offset),
                              64'(got_d.placed_offset));
                compare_field("flush_valid", 64'(want.u.flush_valid),
                              64'(got_u.flush_valid));
                compare_field("flushed_block", 64'(want.d.flushed_block),
                              64'(got_d.flushed_block));
                compare_field("flushed_fill", 64'(want.d.flushed_fill),
                              64'(got_d.flushed_fill));
                compare_field("flushed_no_compress", 64'(want.d.flushed_no_compress),
                              64'(got_d.flushed_no_compress));
                compare_field("status", 64'(want.u.status), 64'(got_u.status));
            end
            // Tally what the block actually reported.
            dup_seen      += (got_u.is_duplicate === 1'b1);
            flush_seen    += (got_u.flush_valid === 1'b1);
            oversize_seen += (got_u.status === fpd_pkg::STATUS_TOO_LARGE);
            full_seen     += (got_u.status === fpd_pkg::STATUS_FULL);
        end
    end

    // Stimulus: directed table, then random phases.
    initial
    begin
        plan_row_t                  row;
        logic [fpd_pkg::LEN_W-1:0]  phase_caps [5];

        // Known values on every input from time zero.
        rst_n         = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tvalid = 1'b0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;

        // Predictor starts from the reset state.
        seen_count  = 0;
        open_valid  = 1'b0;
        open_index  = '0;
        open_fill   = '0;
        open_raw    = 1'b0;
        fresh_index = '0;
        block_cap   = fpd_pkg::MAX_BLOCK_RESET;

        // First fragment after reset opens block 0 at offset 0.
        row_check(32'h0000_0000, 21'd1, 1'b0,
                  outcome(1'b0, 0, 0, 1'b0, 0, 0, 1'b0, fpd_pkg::STATUS_OK));
        // A full-capacity fragment cannot join block 0: close it, open block 1.
        row_check(32'hFFFF_FFFF, 21'd131072, 1'b1,
                  outcome(1'b0, 1, 0, 1'b1, 0, 1, 1'b0, fpd_pkg::STATUS_OK));
        // Repeat of the first fragment hits the table.
        row_check(32'h0000_0000, 21'd1, 1'b0,
                  outcome(1'b1, 0, 0, 1'b0, 0, 0, 1'b0, fpd_pkg::STATUS_OK));
        // Same checksum, new length: a miss; closes the full raw block 1.
        row_check(32'h0000_0000, 21'd2, 1'b0,
                  outcome(1'b0, 2, 0, 1'b1, 1, 131072, 1'b1, fpd_pkg::STATUS_OK));
        // Largest fragment against the reset capacity.
        row_check(32'h0000_0005, 21'd1048576, 1'b0,
                  outcome(1'b0, 0, 0, 1'b0, 0, 0, 1'b0, fpd_pkg::STATUS_TOO_LARGE));
        row_check(32'hFFFF_FFFF, 21'd131072, 1'b0,
                  outcome(1'b1, 1, 0, 1'b0, 0, 0, 1'b0, fpd_pkg::STATUS_OK));
        // Zero-length fragment, placed and recorded, then repeated.
        row_frag(32'h0000_0007, 21'd0, 1'b1);
        row_frag(32'h0000_0007, 21'd0, 1'b0);
        row_frag(32'h0000_0008, 21'd100000, 1'b0);
        // Shrink the capacity below the current fill.
        row_reg(21'(MIN_CAP));
        // Stored fragment now larger than the block still hits.
        row_frag(32'h0000_0008, 21'd100000, 1'b0);
        row_frag(32'h0000_0009, 21'd1, 1'b0);
        row_frag(32'h0000_000A, 21'(MIN_CAP), 1'b1);
        row_check(32'h0000_000B, 21'(MIN_CAP + 1), 1'b0,
                  outcome(1'b0, 0, 0, 1'b0, 0, 0, 1'b0, fpd_pkg::STATUS_TOO_LARGE));
        // Widest capacity: a zero-length fragment after a full block lands at
        // offset 2^20, which wraps to 0 in the 20-bit offset.
        row_reg(21'(MAX_FRAG));
        row_frag(32'h0000_000C, 21'(MAX_FRAG), 1'b0);
        row_frag(32'h0000_000D, 21'd0, 1'b0);
        row_frag(32'h0000_000E, 21'd1, 1'b1);
        row_frag(32'h0000_000C, 21'(MAX_FRAG), 1'b0);
        row_frag(32'hA5A5_5A5A, 21'd1, 1'b0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table.
        foreach (plan_rows[i])
        begin
            row = plan_rows[i];
            if (row.kind == ROW_REG)
            begin
                drain();
                write_max_block(row.bytes);
            end
            else
                send_fragment(row.csum, row.bytes, row.raw, row.typed, row.want);
        end

        // Random phases, each at its own capacity, with back-to-back bursts.
        phase_caps[0] = 21'(MIN_CAP);
        phase_caps[1] = 21'd65536;
        phase_caps[2] = 21'(MAX_FRAG);
        phase_caps[3] = 21'($urandom_range(MIN_CAP, MAX_FRAG));
        phase_caps[4] = fpd_pkg::MAX_BLOCK_RESET;
        foreach (phase_caps[ph])
        begin
            drain();
            write_max_block(phase_caps[ph]);
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                if (n % 20 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                send_random(30);
            end
        end

        // Let any stray word surface before the verdict.
        drain();
        no_idle = 1'b0;
        repeat (TAIL_WAIT) @(posedge clk);

        $display("Sent %0d fragments over %0d capacity settings; %0d duplicates, %0d flushes,",
                 frags_sent, cap_writes, dup_seen, flush_seen);
        $display("%0d oversize and %0d table-full rejects with the table filled to %0d.",
                 oversize_seen, full_seen, seen_count);
        if (mismatches == 0 && placement_q.size() == 0)
            $display("tb_fragment_packer_with_dedup_top: PASS");
        else
            $display("tb_fragment_packer_with_dedup_top: FAIL");
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #30_000_000;
        $display("tb_fragment_packer_with_dedup_top: FAIL");
        $finish;
    end

endmodule
